// ===== src/impedance_ratio_frame_packer_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the impedance ratio frame packer
// Concurrent check wrappers that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef IMPEDANCE_RATIO_FRAME_PACKER_TOP_DEFINES_SVH
`define IMPEDANCE_RATIO_FRAME_PACKER_TOP_DEFINES_SVH
`ifndef SYNTH
`define IRFP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define IRFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define IRFP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define IRFP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/irfp_pkg.sv =====
// ----------------------------------------------------------------------------
// irfp_pkg
// Shared types, constants and the floating-point program of the frame packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package irfp_pkg;

	localparam int COUNT_WRAP = 1000;
	localparam int CNT_W      = 16;
	localparam int FRAME_LEN  = 24;
	localparam int IDX_W      = 5;
	localparam int ACC_N      = 6;
	localparam int RES_N      = 4;
	localparam int MEM_DEPTH  = 13;
	localparam int PROG_LEN   = 28;
	localparam int PC_W       = 5;
	localparam int ADDR_W     = 3;

	localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
	localparam logic [7:0]  SYNC0     = 8'h7F;
	localparam logic [7:0]  SYNC1     = 8'hFF;

	localparam logic [1:0] MODE_RAW   = 2'd0;
	localparam logic [1:0] MODE_RATIO = 2'd1;

	localparam logic REG_MODE = 1'b0;

	// Register file slots.
	localparam int R_AI  = 0;
	localparam int R_AQ  = 1;
	localparam int R_BI  = 2;
	localparam int R_BQ  = 3;
	localparam int R_CI  = 4;
	localparam int R_CQ  = 5;
	localparam int R_P1  = 6;
	localparam int R_P2  = 7;
	localparam int R_DEN = 8;
	localparam int R_P3  = 9;
	localparam int R_P4  = 10;
	localparam int R_NRE = 11;
	localparam int R_NIM = 12;
	// Destinations with bit 4 set go to the result registers.
	localparam int D_RES = 16;

	typedef enum logic [1:0] {
		FOP_CONV,
		FOP_MUL,
		FOP_ADD,
		FOP_DIV
	} fop_t;

	typedef struct packed {
		fop_t       op;
		logic       neg;
		logic [3:0] src_a;
		logic [3:0] src_b;
		logic [4:0] dst;
	} prog_t;

	typedef struct packed {
		logic start;
		fop_t op;
		logic neg;
	} fpu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] result;
	} fpu_rsp_t;

	typedef struct packed {
		logic signed [31:0] acc_a_in;
		logic signed [31:0] acc_a_quad;
		logic signed [31:0] acc_b_in;
		logic signed [31:0] acc_b_quad;
		logic signed [31:0] acc_c_in;
		logic signed [31:0] acc_c_quad;
		logic [15:0]        ecg_word;
		logic [7:0]         packet_index;
		logic [3:0]         mux_select;
	} item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} frame_t;

	function automatic prog_t mk(input fop_t op, input logic neg, input int a, input int b,
			input int d);
		prog_t p;
		p.op    = op;
		p.neg   = neg;
		p.src_a = 4'(a);
		p.src_b = 4'(b);
		p.dst   = 5'(d);
		return p;
	endfunction

	// Ratio program: convert six inputs, then A/B and A/C.
	function automatic prog_t prog_entry(input logic [PC_W-1:0] pc);
		prog_t p;
		unique case (pc)
			5'd0:  p = mk(FOP_CONV, 1'b0, R_AI, R_AI, R_AI);
			5'd1:  p = mk(FOP_CONV, 1'b0, R_AQ, R_AQ, R_AQ);
			5'd2:  p = mk(FOP_CONV, 1'b0, R_BI, R_BI, R_BI);
			5'd3:  p = mk(FOP_CONV, 1'b0, R_BQ, R_BQ, R_BQ);
			5'd4:  p = mk(FOP_CONV, 1'b0, R_CI, R_CI, R_CI);
			5'd5:  p = mk(FOP_CONV, 1'b0, R_CQ, R_CQ, R_CQ);
			5'd6:  p = mk(FOP_MUL, 1'b0, R_BI, R_BI, R_P1);
			5'd7:  p = mk(FOP_MUL, 1'b0, R_BQ, R_BQ, R_P2);
			5'd8:  p = mk(FOP_ADD, 1'b0, R_P1, R_P2, R_DEN);
			5'd9:  p = mk(FOP_MUL, 1'b0, R_AI, R_BI, R_P3);
			5'd10: p = mk(FOP_MUL, 1'b0, R_AQ, R_BQ, R_P4);
			5'd11: p = mk(FOP_ADD, 1'b0, R_P3, R_P4, R_NRE);
			5'd12: p = mk(FOP_MUL, 1'b1, R_AI, R_BQ, R_P3);
			5'd13: p = mk(FOP_MUL, 1'b0, R_AQ, R_BI, R_P4);
			5'd14: p = mk(FOP_ADD, 1'b0, R_P3, R_P4, R_NIM);
			5'd15: p = mk(FOP_DIV, 1'b0, R_NRE, R_DEN, D_RES + 0);
			5'd16: p = mk(FOP_DIV, 1'b0, R_NIM, R_DEN, D_RES + 1);
			5'd17: p = mk(FOP_MUL, 1'b0, R_CI, R_CI, R_P1);
			5'd18: p = mk(FOP_MUL, 1'b0, R_CQ, R_CQ, R_P2);
			5'd19: p = mk(FOP_ADD, 1'b0, R_P1, R_P2, R_DEN);
			5'd20: p = mk(FOP_MUL, 1'b0, R_AI, R_CI, R_P3);
			5'd21: p = mk(FOP_MUL, 1'b0, R_AQ, R_CQ, R_P4);
			5'd22: p = mk(FOP_ADD, 1'b0, R_P3, R_P4, R_NRE);
			5'd23: p = mk(FOP_MUL, 1'b1, R_AI, R_CQ, R_P3);
			5'd24: p = mk(FOP_MUL, 1'b0, R_AQ, R_CI, R_P4);
			5'd25: p = mk(FOP_ADD, 1'b0, R_P3, R_P4, R_NIM);
			5'd26: p = mk(FOP_DIV, 1'b0, R_NRE, R_DEN, D_RES + 2);
			5'd27: p = mk(FOP_DIV, 1'b0, R_NIM, R_DEN, D_RES + 3);
			default: p = mk(FOP_CONV, 1'b0, R_AI, R_AI, R_AI);
		endcase
		return p;
	endfunction

endpackage

// ===== src/irfp_fpu.sv =====
// ----------------------------------------------------------------------------
// irfp_fpu
// Multi-cycle binary32 unit: int32 conversion, multiply, add and divide,
// all rounding to nearest even. Operands are normal numbers or zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irfp_fpu (
	input  logic               clk,
	input  logic               arst_n,
	input  irfp_pkg::fpu_req_t req,
	input  logic [31:0]        op_a,
	input  logic [31:0]        op_b,
	output irfp_pkg::fpu_rsp_t rsp
);

	typedef enum logic [2:0] {
		F_IDLE,
		F_CNORM,
		F_MULN,
		F_ALIGN,
		F_ANORM,
		F_DIVI,
		F_DNORM,
		F_ROUND
	} fstate_t;

	fstate_t     state_q;
	logic        done_q;
	logic [31:0] res_q;
	logic        sign_q;
	logic [9:0]  exp_q;
	logic [31:0] mag_q;
	logic [47:0] prod_q;
	logic [26:0] xa_q;
	logic [26:0] xb_q;
	logic [7:0]  dsh_q;
	logic        sub_q;
	logic [27:0] acc_q;
	logic [24:0] rem_q;
	logic [23:0] mb_q;
	logic [25:0] quo_q;
	logic [4:0]  cnt_q;
	logic [25:0] rnd_q;

	logic        sa, sb, a_zero, b_zero, a_ge_b;
	logic [7:0]  ea, eb;
	logic [23:0] ma, mb;

	always_comb begin
		ea     = op_a[30:23];
		eb     = op_b[30:23];
		ma     = {1'b1, op_a[22:0]};
		mb     = {1'b1, op_b[22:0]};
		sa     = op_a[31] ^ req.neg;
		sb     = op_b[31];
		a_zero = (ea == 8'd0);
		b_zero = (eb == 8'd0);
		a_ge_b = (op_a[30:0] >= op_b[30:0]);
	end

	// Alignment of the smaller addend with a sticky bit.
	logic [26:0] mask, sh;
	logic [27:0] sum;
	always_comb begin
		mask = ~(27'h7FF_FFFF << dsh_q[4:0]);
		if (dsh_q >= 8'd27) begin
			sh = {26'd0, |xb_q};
		end else begin
			sh = (xb_q >> dsh_q[4:0]) | {26'd0, |(xb_q & mask)};
		end
		sum = sub_q ? ({1'b0, xa_q} - {1'b0, sh}) : ({1'b0, xa_q} + {1'b0, sh});
	end

	logic        rem_ge;
	logic [24:0] diff;
	always_comb begin
		rem_ge = (rem_q >= {1'b0, mb_q});
		diff   = rem_ge ? (rem_q - {1'b0, mb_q}) : rem_q;
	end

	logic        inc;
	logic [24:0] m25;
	logic [9:0]  exp_r;
	logic [22:0] frac;
	always_comb begin
		inc   = rnd_q[1] & (rnd_q[0] | rnd_q[2]);
		m25   = {1'b0, rnd_q[25:2]} + {24'd0, inc};
		exp_r = m25[24] ? (exp_q + 10'd1) : exp_q;
		frac  = m25[24] ? m25[23:1] : m25[22:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (req.start) begin
						unique case (req.op)
							irfp_pkg::FOP_CONV: begin
								if (op_a == 32'd0) begin
									res_q  <= 32'd0;
									done_q <= 1'b1;
								end else begin
									sign_q  <= op_a[31];
									mag_q   <= op_a[31] ? (~op_a + 32'd1) : op_a;
									exp_q   <= 10'd158;
									state_q <= F_CNORM;
								end
							end
							irfp_pkg::FOP_MUL: begin
								if (a_zero || b_zero) begin
									res_q  <= {sa ^ sb, 31'd0};
									done_q <= 1'b1;
								end else begin
									prod_q  <= {24'd0, ma} * {24'd0, mb};
									sign_q  <= sa ^ sb;
									exp_q   <= {2'b0, ea} + {2'b0, eb} - 10'd127;
									state_q <= F_MULN;
								end
							end
							irfp_pkg::FOP_ADD: begin
								if (a_zero && b_zero) begin
									res_q  <= {sa & sb, 31'd0};
									done_q <= 1'b1;
								end else if (a_zero) begin
									res_q  <= op_b;
									done_q <= 1'b1;
								end else if (b_zero) begin
									res_q  <= {sa, op_a[30:0]};
									done_q <= 1'b1;
								end else begin
									sub_q   <= sa ^ sb;
									state_q <= F_ALIGN;
									if (a_ge_b) begin
										sign_q <= sa;
										exp_q  <= {2'b0, ea};
										xa_q   <= {ma, 3'b000};
										xb_q   <= {mb, 3'b000};
										dsh_q  <= ea - eb;
									end else begin
										sign_q <= sb;
										exp_q  <= {2'b0, eb};
										xa_q   <= {mb, 3'b000};
										xb_q   <= {ma, 3'b000};
										dsh_q  <= eb - ea;
									end
								end
							end
							irfp_pkg::FOP_DIV: begin
								if (b_zero) begin
									res_q  <= irfp_pkg::QNAN_BITS;
									done_q <= 1'b1;
								end else if (a_zero) begin
									res_q  <= {sa ^ sb, 31'd0};
									done_q <= 1'b1;
								end else begin
									sign_q  <= sa ^ sb;
									exp_q   <= {2'b0, ea} - {2'b0, eb} + 10'd127;
									rem_q   <= {1'b0, ma};
									mb_q    <= mb;
									quo_q   <= 26'd0;
									cnt_q   <= 5'd25;
									state_q <= F_DIVI;
								end
							end
							default: state_q <= F_IDLE;
						endcase
					end
				end
				F_CNORM: begin
					if (mag_q[31]) begin
						rnd_q   <= {mag_q[31:8], mag_q[7], |mag_q[6:0]};
						state_q <= F_ROUND;
					end else begin
						mag_q <= {mag_q[30:0], 1'b0};
						exp_q <= exp_q - 10'd1;
					end
				end
				F_MULN: begin
					if (prod_q[47]) begin
						rnd_q <= {prod_q[47:24], prod_q[23], |prod_q[22:0]};
						exp_q <= exp_q + 10'd1;
					end else begin
						rnd_q <= {prod_q[46:23], prod_q[22], |prod_q[21:0]};
					end
					state_q <= F_ROUND;
				end
				F_ALIGN: begin
					acc_q   <= sum;
					state_q <= F_ANORM;
				end
				F_ANORM: begin
					if (acc_q[27]) begin
						acc_q <= {1'b0, acc_q[27:2], acc_q[1] | acc_q[0]};
						exp_q <= exp_q + 10'd1;
					end else if (acc_q == 28'd0) begin
						// Exact cancellation gives positive zero.
						res_q   <= 32'd0;
						done_q  <= 1'b1;
						state_q <= F_IDLE;
					end else if (!acc_q[26]) begin
						acc_q <= {acc_q[26:0], 1'b0};
						exp_q <= exp_q - 10'd1;
					end else begin
						rnd_q   <= {acc_q[26:3], acc_q[2], |acc_q[1:0]};
						state_q <= F_ROUND;
					end
				end
				F_DIVI: begin
					quo_q <= {quo_q[24:0], rem_ge};
					rem_q <= {diff[23:0], 1'b0};
					if (cnt_q == 5'd0) begin
						state_q <= F_DNORM;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				F_DNORM: begin
					if (quo_q[25]) begin
						rnd_q <= {quo_q[25:2], quo_q[1], quo_q[0] | (rem_q != 25'd0)};
					end else begin
						rnd_q <= {quo_q[24:1], quo_q[0], rem_q != 25'd0};
						exp_q <= exp_q - 10'd1;
					end
					state_q <= F_ROUND;
				end
				F_ROUND: begin
					res_q   <= {sign_q, exp_r[7:0], frac};
					done_q  <= 1'b1;
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

// ===== src/irfp_seq.sv =====
// ----------------------------------------------------------------------------
// irfp_seq
// Runs the ratio program on the shared floating-point unit, keeping
// intermediate values in a small register file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irfp_seq (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic [irfp_pkg::ACC_N-1:0][31:0]         acc,
	output logic                                     done,
	output logic [irfp_pkg::RES_N-1:0][31:0]         res
);

	typedef enum logic [1:0] {
		Q_IDLE,
		Q_READ,
		Q_ISSUE,
		Q_WAIT
	} qstate_t;

	qstate_t                         state_q;
	logic [irfp_pkg::PC_W-1:0]       pc_q;
	logic                            done_q;
	logic [31:0]                     rd_a_q;
	logic [31:0]                     rd_b_q;
	logic [irfp_pkg::RES_N-1:0][31:0] res_q;
	logic [31:0]                     mem [irfp_pkg::MEM_DEPTH];

	irfp_pkg::prog_t    ent;
	irfp_pkg::fpu_req_t req;
	irfp_pkg::fpu_rsp_t rsp;
	logic [31:0]        op_a;
	logic               wr_mem;

	always_comb begin
		ent       = irfp_pkg::prog_entry(pc_q);
		req.start = (state_q == Q_ISSUE);
		req.op    = ent.op;
		req.neg   = ent.neg;
		op_a      = (ent.op == irfp_pkg::FOP_CONV) ? acc[ent.src_a[2:0]] : rd_a_q;
		wr_mem    = (state_q == Q_WAIT) && rsp.done && !ent.dst[4];
	end

	irfp_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.op_a   (op_a),
		.op_b   (rd_b_q),
		.rsp    (rsp)
	);

	always_ff @(posedge clk) begin
		if (wr_mem) begin
			mem[ent.dst[3:0]] <= rsp.result;
		end
		if (state_q == Q_READ) begin
			rd_a_q <= mem[ent.src_a];
			rd_b_q <= mem[ent.src_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= Q_IDLE;
			pc_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				Q_IDLE: begin
					if (start) begin
						pc_q    <= '0;
						state_q <= Q_READ;
					end
				end
				Q_READ:  state_q <= Q_ISSUE;
				Q_ISSUE: state_q <= Q_WAIT;
				Q_WAIT: begin
					if (rsp.done) begin
						if (ent.dst[4]) begin
							res_q[ent.dst[1:0]] <= rsp.result;
						end
						if (pc_q == irfp_pkg::PC_W'(irfp_pkg::PROG_LEN - 1)) begin
							done_q  <= 1'b1;
							state_q <= Q_IDLE;
						end else begin
							pc_q    <= pc_q + 1'b1;
							state_q <= Q_READ;
						end
					end
				end
				default: state_q <= Q_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== src/impedance_ratio_frame_packer_top.sv =====
// ----------------------------------------------------------------------------
// impedance_ratio_frame_packer_top
// Packs accumulator data into 24-byte frames, raw, as complex ratios or with no payload.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  item     | in        | item_valid / item_stall | irfp_pkg::item_t
//  frame    | out       | frame_valid/frame_stall | irfp_pkg::frame_t, one byte
//  config   | in        | APB write, pready high  | pack_mode at address 0
//
// A frame leaves at one byte per cycle while the output is not stalled, in raw
// and no-payload mode. Ratio mode first runs 28 operations on the shared
// floating-point unit, each an operand fetch and issue followed by a wait on
// the unit, before the first payload byte. item_stall is high from the accepted
// transaction until the last byte is loaded into the output register. A stalled
// output holds its byte. Reset clears the mode and the frame counter.
`timescale 1ns / 1ps

`include "impedance_ratio_frame_packer_top_defines.svh"

module impedance_ratio_frame_packer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  irfp_pkg::item_t             item_data,
	output logic                        frame_valid,
	input  logic                        frame_stall,
	output irfp_pkg::frame_t            frame_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [irfp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	typedef enum logic [1:0] {
		T_IDLE,
		T_CALC,
		T_SEND
	} tstate_t;

	tstate_t                          state_q;
	logic [1:0]                       mode_q;
	logic [irfp_pkg::CNT_W-1:0]       count_q;
	logic [irfp_pkg::CNT_W-1:0]       snap_q;
	logic [irfp_pkg::IDX_W-1:0]       idx_q;
	irfp_pkg::item_t                  item_q;
	irfp_pkg::frame_t                 frame_q;
	logic                             frame_valid_q;

	logic                             accept;
	logic                             seq_start;
	logic                             seq_done;
	logic [irfp_pkg::ACC_N-1:0][31:0] acc_w;
	logic [irfp_pkg::RES_N-1:0][31:0] res_w;
	logic [irfp_pkg::CNT_W-1:0]       count_inc;
	logic [irfp_pkg::IDX_W-1:0]       sel;
	logic [31:0]                      raw_w;
	logic [31:0]                      rat_w;
	logic [7:0]                       byte_d;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == irfp_pkg::REG_MODE) ? {30'd0, mode_q} : 32'd0;

	assign accept     = item_valid && (state_q == T_IDLE);
	assign item_stall = (state_q != T_IDLE);
	assign seq_start  = accept && (mode_q == irfp_pkg::MODE_RATIO);
	assign count_inc  = count_q + 1'b1;

	always_comb begin
		acc_w[0] = item_q.acc_a_in;
		acc_w[1] = item_q.acc_a_quad;
		acc_w[2] = item_q.acc_b_in;
		acc_w[3] = item_q.acc_b_quad;
		acc_w[4] = item_q.acc_c_in;
		acc_w[5] = item_q.acc_c_quad;
	end

	// The sequencer reads the captured item, which holds for the whole frame.
	irfp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seq_start),
		.acc    (acc_w),
		.done   (seq_done),
		.res    (res_w)
	);

	// Frame byte selection; payload bytes start at index two.
	always_comb begin
		sel    = idx_q - 5'd2;
		raw_w  = acc_w[sel[3:1]];
		rat_w  = res_w[sel[3:2]];
		byte_d = 8'd0;
		case (idx_q) inside
			5'd0: byte_d = irfp_pkg::SYNC0;
			5'd1: byte_d = irfp_pkg::SYNC1;
			[5'd2:5'd17]: begin
				if (mode_q == irfp_pkg::MODE_RAW && idx_q <= 5'd13) begin
					byte_d = sel[0] ? raw_w[31:24] : raw_w[23:16];
				end else if (mode_q == irfp_pkg::MODE_RATIO) begin
					case (sel[1:0])
						2'd0:    byte_d = rat_w[7:0];
						2'd1:    byte_d = rat_w[15:8];
						2'd2:    byte_d = rat_w[23:16];
						default: byte_d = rat_w[31:24];
					endcase
				end
			end
			5'd18: byte_d = item_q.ecg_word[7:0];
			5'd19: byte_d = item_q.ecg_word[15:8];
			5'd20: byte_d = snap_q[7:0];
			5'd21: byte_d = snap_q[15:8];
			5'd22: byte_d = {4'd0, item_q.mux_select};
			5'd23: byte_d = item_q.packet_index;
			default: byte_d = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= T_IDLE;
			mode_q        <= irfp_pkg::MODE_RAW;
			count_q       <= '0;
			idx_q         <= '0;
			frame_valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr[2] == irfp_pkg::REG_MODE) begin
				mode_q <= pwdata[1:0];
			end
			unique case (state_q)
				T_IDLE: begin
					if (frame_valid_q && !frame_stall) begin
						frame_valid_q <= 1'b0;
					end
					if (accept) begin
						item_q  <= item_data;
						snap_q  <= count_q;
						count_q <= (count_inc == 16'(irfp_pkg::COUNT_WRAP)) ? '0 : count_inc;
						idx_q   <= '0;
						state_q <= (mode_q == irfp_pkg::MODE_RATIO) ? T_CALC : T_SEND;
					end
				end
				T_CALC: begin
					if (frame_valid_q && !frame_stall) begin
						frame_valid_q <= 1'b0;
					end
					if (seq_done) begin
						state_q <= T_SEND;
					end
				end
				T_SEND: begin
					if (!frame_valid_q || !frame_stall) begin
						frame_valid_q       <= 1'b1;
						frame_q.frame_byte  <= byte_d;
						frame_q.frame_end   <= (idx_q == 5'(irfp_pkg::FRAME_LEN - 1));
						if (idx_q == 5'(irfp_pkg::FRAME_LEN - 1)) begin
							state_q <= T_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign frame_valid = frame_valid_q;
	assign frame_data  = frame_q;

	`IRFP_ASSERT_IMPLIES(a_seq_done_in_calc, clk, arst_n, seq_done, state_q == T_CALC)
	`IRFP_ASSERT_NEXT(a_accept_restarts_frame, clk, arst_n, item_valid && !item_stall, idx_q == 5'd0)

endmodule

// ===== bench/frame_packer_checker.sv =====
// ----------------------------------------------------------------------------
// Frame packer checker
// Watches the item, frame and register channels, predicts each 24-byte frame
// with binary32 arithmetic built on double precision, and compares bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_packer_checker
	import irfp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_stall,
	input  item_t               item_data,
	input  logic                frame_valid,
	input  logic                frame_stall,
	input  frame_t              frame_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	output int                  errors,
	output int                  pending
);

	logic [1:0]  mode_q;
	logic [15:0] frame_count;
	frame_t      frame_queue[$];

	// Rounds a double to binary32, nearest even. Results here are never
	// subnormal or out of range, and NaN is handled by the caller.
	function automatic logic [31:0] to_f32(input real x);
		logic [63:0] d;
		logic [30:0] mag;
		logic [28:0] rem;
		int          ex;
		d = $realtobits(x);
		if (d[62:0] == 63'd0)
			return {d[63], 31'd0};
		ex = int'(d[62:52]) - 896;
		mag = {ex[7:0], d[51:29]};
		rem = d[28:0];
		if (rem > 29'h1000_0000 || (rem == 29'h1000_0000 && mag[0]))
			mag = mag + 31'd1;
		return {d[63], mag};
	endfunction

	function automatic real from_f32(input logic [31:0] b);
		int ex;
		if (b[30:0] == 31'd0)
			return $bitstoreal({b[31], 63'd0});
		ex = int'(b[30:23]) + 896;
		return $bitstoreal({b[31], ex[10:0], b[22:0], 29'd0});
	endfunction

	// Sums, products and quotients of two binary32 values are correctly
	// rounded when done in double and then rounded once to binary32.
	function automatic real rnd(input real x);
		return from_f32(to_f32(x));
	endfunction

	function automatic void complex_quotient(input real ai, input real aq, input real di,
			input real dq, output logic [31:0] re, output logic [31:0] im);
		real den, nre, nim;
		den = rnd(rnd(di * di) + rnd(dq * dq));
		nre = rnd(rnd(ai * di) + rnd(aq * dq));
		nim = rnd(rnd((-ai) * dq) + rnd(aq * di));
		if (den == 0.0) begin
			re = QNAN_BITS;
			im = QNAN_BITS;
		end else begin
			re = to_f32(nre / den);
			im = to_f32(nim / den);
		end
	endfunction

	task automatic predict_frame(input item_t it);
		logic [7:0]  fb[FRAME_LEN];
		logic [31:0] acc[ACC_N];
		logic [31:0] q[RES_N];
		real         fv[ACC_N];
		frame_t      fr;
		acc = '{it.acc_a_in, it.acc_a_quad, it.acc_b_in, it.acc_b_quad, it.acc_c_in,
			it.acc_c_quad};
		foreach (fb[i])
			fb[i] = 8'd0;
		fb[0] = SYNC0;
		fb[1] = SYNC1;
		if (mode_q == MODE_RAW) begin
			for (int i = 0; i < ACC_N; i++) begin
				fb[2 + 2 * i] = acc[i][23:16];
				fb[3 + 2 * i] = acc[i][31:24];
			end
		end else if (mode_q == MODE_RATIO) begin
			for (int i = 0; i < ACC_N; i++)
				fv[i] = rnd(real'($signed(acc[i])));
			complex_quotient(fv[0], fv[1], fv[2], fv[3], q[0], q[1]);
			complex_quotient(fv[0], fv[1], fv[4], fv[5], q[2], q[3]);
			for (int i = 0; i < RES_N; i++)
				for (int k = 0; k < 4; k++)
					fb[2 + 4 * i + k] = q[i][8 * k +: 8];
		end
		fb[18] = it.ecg_word[7:0];
		fb[19] = it.ecg_word[15:8];
		fb[20] = frame_count[7:0];
		fb[21] = frame_count[15:8];
		fb[22] = {4'd0, it.mux_select};
		fb[23] = it.packet_index;
		frame_count = frame_count + 16'd1;
		if (frame_count == 16'(COUNT_WRAP))
			frame_count = 16'd0;
		for (int i = 0; i < FRAME_LEN; i++) begin
			fr.frame_byte = fb[i];
			fr.frame_end  = (i == FRAME_LEN - 1);
			frame_queue.push_back(fr);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_t exp_fr;
		if (!arst_n) begin
			mode_q      = MODE_RAW;
			frame_count = 16'd0;
			frame_queue.delete();
			errors      = 0;
		end else begin
			if (frame_valid && !frame_stall) begin
				if (frame_queue.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%t: unexpected frame byte %h end %b", $realtime,
							frame_data.frame_byte, frame_data.frame_end);
				end else begin
					exp_fr = frame_queue.pop_front();
					if (exp_fr.frame_byte !== frame_data.frame_byte ||
							exp_fr.frame_end !== frame_data.frame_end) begin
						errors++;
						if (errors <= 10)
							$display("%t: frame mismatch: byte exp %h got %h, end exp %b got %b",
								$realtime, exp_fr.frame_byte, frame_data.frame_byte,
								exp_fr.frame_end, frame_data.frame_end);
					end
				end
			end
			if (item_valid && !item_stall)
				predict_frame(item_data);
			if (psel && penable && pwrite && pready && paddr == '0)
				mode_q = pwdata[1:0];
		end
		pending = frame_queue.size();
	end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Frame packer testbench
// Drives accumulator items in every packing mode with random gaps and output
// stalls, steps the mode register between phases and runs a burst of
// back-to-back frames near the end; the checker compares every frame byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import irfp_pkg::*;

	localparam logic [1:0] MODE_NONE   = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic                clk;
	logic                arst_n;
	logic                item_valid;
	logic                item_stall;
	item_t               item_data;
	logic                frame_valid;
	logic                frame_stall;
	frame_t              frame_data;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	int                  errors;
	int                  pending;
	bit                  no_stall;

	impedance_ratio_frame_packer_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item_data(item_data),
		.frame_valid(frame_valid), .frame_stall(frame_stall), .frame_data(frame_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	frame_packer_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item_data(item_data),
		.frame_valid(frame_valid), .frame_stall(frame_stall), .frame_data(frame_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	initial begin
		#8_000_000;
		$display("tb_top: errors");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 0;
		if (r < 9)
			return $urandom_range(1, 3);
		return $urandom_range(20, 80);
	endfunction

	// Output stall in runs: mostly short, now and then a long one.
	always @(posedge clk) begin
		int run_left;
		if (!arst_n || no_stall) begin
			frame_stall <= 1'b0;
			run_left = 0;
		end else if (run_left > 0) begin
			run_left--;
		end else if ($urandom_range(0, 2) == 0) begin
			frame_stall <= 1'b1;
			run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : gap_len();
		end else begin
			frame_stall <= 1'b0;
			run_left = $urandom_range(0, 30);
		end
	end

	function automatic logic [31:0] rand_acc();
		case ($urandom_range(0, 5))
			0:       return 32'd0;
			1:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			2, 3:    return $urandom >> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	function automatic item_t rand_item();
		item_t it;
		it.acc_a_in     = rand_acc();
		it.acc_a_quad   = rand_acc();
		it.acc_b_in     = rand_acc();
		it.acc_b_quad   = rand_acc();
		it.acc_c_in     = rand_acc();
		it.acc_c_quad   = rand_acc();
		it.ecg_word     = 16'($urandom);
		it.packet_index = 8'($urandom);
		it.mux_select   = 4'($urandom);
		return it;
	endfunction

	task automatic send_item(input item_t it, input int gap);
		logic stalled;
		item_valid <= 1'b1;
		item_data  <= it;
		forever begin
			@(negedge clk);
			stalled = item_stall;
			@(posedge clk);
			if (!stalled)
				break;
		end
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0 || item_stall);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mode(input logic [1:0] m);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= '0;
		pwdata  <= {30'd0, m};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic directed_items();
		item_t it;
		it = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 8'hFF, 4'hF};
		send_item(it, gap_len());
		it = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 16'h0000, 8'h00, 4'h0};
		send_item(it, gap_len());
		// Both divisors zero: quotients become quiet NaN.
		it = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'h8001, 8'h80, 4'h8};
		send_item(it, gap_len());
		it = '{32'd7, -32'sd3, 32'd0, 32'd0, 32'd2, 32'd1, 16'h1234, 8'h55, 4'h5};
		send_item(it, gap_len());
		it = '{32'd0, 32'd0, 32'd5, -32'sd9, 32'd0, 32'd0, 16'hA5A5, 8'hAA, 4'hA};
		send_item(it, gap_len());
		it = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'h8000_0000, 32'hFFFF_FFFF,
			32'd1, 16'h5A5A, 8'h01, 4'h1};
		send_item(it, 0);
		it = '{32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210,
			32'h00FF_FF00, 32'hFF00_00FF, 16'h00FF, 8'hFE, 4'h7};
		send_item(it, gap_len());
	endtask

	initial begin
		logic [1:0] modes[5];
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		item_data   = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		no_stall    = 1'b0;
		modes       = '{MODE_RATIO, MODE_NONE, MODE_RAW, MODE_UNUSED, MODE_RATIO};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_items();
		wait_idle();
		write_mode(MODE_RATIO);
		directed_items();
		foreach (modes[p]) begin
			wait_idle();
			write_mode(modes[p]);
			repeat (18) send_item(rand_item(), gap_len());
		end

		// Back-to-back frames with the output never stalled.
		wait_idle();
		write_mode(MODE_NONE);
		no_stall = 1'b1;
		repeat (10) send_item(rand_item(), 0);
		no_stall = 1'b0;
		repeat (10) send_item(rand_item(), gap_len());

		wait_idle();
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
